[rtl/core/iprcl_pkg.sv]
// ----------------------------------------------------------------------------
// iprcl_pkg
// Shared types, opcodes and helpers for the IP range country lookup core.
// ----------------------------------------------------------------------------
package iprcl_pkg;

    // Operation codes carried in the input tuser
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    // Width of the reported entry count
    localparam int unsigned COUNT_OUT_W = 13;

    // One stored range: start in the low bits, country code on top
    typedef struct packed {
        logic [15:0] code;
        logic [31:0] last_ip;
        logic [31:0] start_ip;
    } t_row;

    // Input payload, last field in the lowest bits
    typedef struct packed {
        logic [15:0] wanted_country;
        logic [31:0] query_ip;
        logic [15:0] range_country;
        logic [31:0] range_end;
        logic [31:0] range_start;
    } t_in_data;

    // Result payload, last field in the lowest bits
    typedef struct packed {
        logic [COUNT_OUT_W-1:0] entry_count;
        logic                   country_match;
        logic [15:0]            found_country;
        logic                   hit;
        logic                   status;
    } t_out_data;

    // Uppercase one ASCII letter, other bytes pass unchanged
    function automatic logic [7:0] upper_byte(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h61 && b <= 8'h7A) begin
            r = b - 8'h20;
        end
        return r;
    endfunction

    function automatic logic [15:0] upper_code(input logic [15:0] c);
        return {upper_byte(c[15:8]), upper_byte(c[7:0])};
    endfunction

endpackage

[rtl/core/ip_range_country_lookup_core.sv]
// ----------------------------------------------------------------------------
// ip_range_country_lookup_core
// Sorted IPv4 range table with binary-search lookup and in-place insert.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Signals                          | Contents
//  ---------+-----+----------------------------------+---------------------------
//  s (cmd)  | in  | i_s_tvalid/o_s_tready/tdata/tuser| opcode in tuser, operands
//  m (rslt) | out | o_m_tvalid/i_m_tready/tdata      | status, hit, code, count
//
//  Steps: clear and the unused opcode go straight to the result step; a query
//  runs k search probes (read, then compare), k <= floor(log2(count))+1; an
//  insert searches, then moves the m entries above its slot.
//  Reset clears the count and control state; the table memory is not cleared.
//  A result waits in the output register; a new command is taken meanwhile,
//  and the core only stalls at its final step if that register is still full.
// ----------------------------------------------------------------------------
module ip_range_country_lookup_core
    import iprcl_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 4096
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // command stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // range_start, range_end, range_country, query_ip, wanted_country
    input  logic [127:0] i_s_tdata,
    // opcode
    input  logic [1:0]   i_s_tuser,
    // result stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // status, hit, found_country, country_match, entry_count
    output logic [31:0]  o_m_tdata
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SRD   = 5'b00010,
        ST_SCMP  = 5'b00100,
        ST_SHIFT = 5'b01000,
        ST_FIN   = 5'b10000
    } t_state;

    // Table memory
    logic [79:0]   mem [TABLE_DEPTH];
    t_row          r_rdata;
    logic          s_re;
    logic [AW-1:0] s_ra;
    logic          s_we;
    logic [AW-1:0] s_wa;
    t_row          s_wd;

    // Control and operand registers
    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_mid, n_mid;
    logic [CW-1:0] r_rd_next, n_rd_next;
    logic          r_pend, n_pend;
    logic [AW-1:0] r_pend_wa, n_pend_wa;
    t_op           r_op, n_op;
    logic          r_status, n_status;
    logic [31:0]   r_key, n_key;
    logic [31:0]   r_last, n_last;
    logic [15:0]   r_code, n_code;
    logic [15:0]   r_want, n_want;
    logic          r_cand_vld, n_cand_vld;
    logic [31:0]   r_cand_end, n_cand_end;
    logic [15:0]   r_cand_code, n_cand_code;
    logic          r_out_vld, n_out_vld;
    t_out_data     r_out, n_out;

    t_in_data      s_in;
    logic [CW:0]   s_sum;
    logic [CW-1:0] s_mid;
    logic [CW-1:0] s_rd_prev;
    logic          s_accept;
    logic          s_hit;
    logic [CW+COUNT_OUT_W-1:0] s_count_ext;

    assign s_in       = t_in_data'(i_s_tdata);
    assign o_s_tready = (r_state == ST_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out;

    // Search midpoint and shift read index
    assign s_sum     = {1'b0, r_lo} + {1'b0, r_hi};
    assign s_mid     = s_sum[CW:1];
    assign s_rd_prev = r_rd_next - CW'(1);

    // Query outcome from the best candidate seen during the search
    assign s_hit       = (r_op == OP_QUERY) && r_cand_vld && (r_key <= r_cand_end);
    assign s_count_ext = {{COUNT_OUT_W{1'b0}}, r_count};

    // Next-state and datapath control
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_rd_next   = r_rd_next;
        n_pend      = r_pend;
        n_pend_wa   = r_pend_wa;
        n_op        = r_op;
        n_status    = r_status;
        n_key       = r_key;
        n_last      = r_last;
        n_code      = r_code;
        n_want      = r_want;
        n_cand_vld  = r_cand_vld;
        n_cand_end  = r_cand_end;
        n_cand_code = r_cand_code;
        n_out_vld   = r_out_vld;
        n_out       = r_out;
        s_re        = 1'b0;
        s_ra        = s_mid[AW-1:0];
        s_we        = 1'b0;
        s_wa        = r_pend_wa;
        s_wd        = r_rdata;

        // Result register drains independently
        if (r_out_vld && i_m_tready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_op       = t_op'(i_s_tuser);
                    n_status   = 1'b0;
                    n_lo       = '0;
                    n_hi       = r_count;
                    n_cand_vld = 1'b0;
                    n_code     = upper_code(s_in.range_country);
                    n_want     = s_in.wanted_country;
                    unique case (t_op'(i_s_tuser))
                        OP_CLEAR: begin
                            n_count = '0;
                            n_state = ST_FIN;
                        end
                        OP_INSERT: begin
                            // swap a reversed range
                            if (s_in.range_end < s_in.range_start) begin
                                n_key  = s_in.range_end;
                                n_last = s_in.range_start;
                            end else begin
                                n_key  = s_in.range_start;
                                n_last = s_in.range_end;
                            end
                            if (r_count >= DEPTH_C) begin
                                n_status = 1'b1;
                                n_state  = ST_FIN;
                            end else begin
                                n_state  = ST_SRD;
                            end
                        end
                        OP_QUERY: begin
                            n_key   = s_in.query_ip;
                            n_state = ST_SRD;
                        end
                        default: begin
                            n_state = ST_FIN;
                        end
                    endcase
                end
            end

            // Issue a probe read or finish the search
            ST_SRD: begin
                if (r_lo < r_hi) begin
                    s_re    = 1'b1;
                    s_ra    = s_mid[AW-1:0];
                    n_mid   = s_mid;
                    n_state = ST_SCMP;
                end else if (r_op == OP_INSERT) begin
                    n_rd_next = r_count;
                    n_pend    = 1'b0;
                    n_state   = ST_SHIFT;
                end else begin
                    n_state = ST_FIN;
                end
            end

            // Narrow the window; remember the last start not above the key
            ST_SCMP: begin
                if (r_rdata.start_ip > r_key) begin
                    n_hi = r_mid;
                end else begin
                    n_lo        = r_mid + CW'(1);
                    n_cand_vld  = 1'b1;
                    n_cand_end  = r_rdata.last_ip;
                    n_cand_code = r_rdata.code;
                end
                n_state = ST_SRD;
            end

            // Move entries up one slot, top first, then place the new row
            ST_SHIFT: begin
                if (r_pend) begin
                    s_we = 1'b1;
                    s_wa = r_pend_wa;
                    s_wd = r_rdata;
                end
                if (r_rd_next > r_lo) begin
                    s_re      = 1'b1;
                    s_ra      = s_rd_prev[AW-1:0];
                    n_pend    = 1'b1;
                    n_pend_wa = r_rd_next[AW-1:0];
                    n_rd_next = s_rd_prev;
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else begin
                    s_we    = 1'b1;
                    s_wa    = r_lo[AW-1:0];
                    s_wd    = '{code: r_code, last_ip: r_last, start_ip: r_key};
                    n_count = r_count + CW'(1);
                    n_state = ST_FIN;
                end
            end

            // Load the result once the output register is free
            ST_FIN: begin
                if (!r_out_vld || i_m_tready) begin
                    n_out_vld           = 1'b1;
                    n_out.status        = r_status;
                    n_out.hit           = s_hit;
                    n_out.found_country = s_hit ? r_cand_code : 16'h0000;
                    n_out.country_match = s_hit && (r_cand_code == r_want);
                    n_out.entry_count   = s_count_ext[COUNT_OUT_W-1:0];
                    n_state             = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Table memory, registered read
    always_ff @(posedge i_clk) begin
        if (s_we) begin
            mem[s_wa] <= s_wd;
        end
        if (s_re) begin
            r_rdata <= t_row'(mem[s_ra]);
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_out_vld <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_out_vld <= n_out_vld;
            r_pend    <= n_pend;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_mid       <= n_mid;
        r_rd_next   <= n_rd_next;
        r_pend_wa   <= n_pend_wa;
        r_op        <= n_op;
        r_status    <= n_status;
        r_key       <= n_key;
        r_last      <= n_last;
        r_code      <= n_code;
        r_want      <= n_want;
        r_cand_vld  <= n_cand_vld;
        r_cand_end  <= n_cand_end;
        r_cand_code <= n_cand_code;
        r_out       <= n_out;
    end

endmodule
